// ===== sv/lrp_pkg.sv =====
package lrp_pkg;

  // Field widths of the request, result and configuration, and the default frame count.
  localparam int PAGE_BITS  = 16;
  localparam int CFG_W      = 4;
  localparam int FRAMES_DEF = 8;
  localparam int FAULT_W    = 32;
  localparam int FIDX_W     = 3;

  // Frame count after reset.
  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(3);

  // One request item.
  typedef struct packed {
    logic [PAGE_BITS-1:0] page_number;
    logic                 last_request;
  } in_t;

  // One result item.
  typedef struct packed {
    logic                 hit;
    logic [FIDX_W-1:0]    frame_sel;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FAULT_W-1:0]   fault_count;
  } out_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DECIDE,
    ST_SCAN,
    ST_EVICT
  } state_t;

  // How the chosen frame is updated at commit time.
  typedef enum logic [1:0] {
    CK_HIT,
    CK_FILL,
    CK_EVICT
  } commit_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load;
    logic         match;
    logic         scan_init;
    logic         scan_step;
    logic         commit;
    commit_kind_t kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic any_hit;
    logic any_empty;
    logic scan_last;
  } status_t;

endpackage

// ===== sv/lrp_datapath.sv =====
module lrp_datapath #(
  parameter int FRAMES = lrp_pkg::FRAMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lrp_pkg::CFG_W-1:0]  cfg_wdata,
  input  lrp_pkg::in_t               in_req,
  input  lrp_pkg::cmd_t              cmd,
  output lrp_pkg::status_t           status,
  output logic                       out_valid,
  output lrp_pkg::out_t              out_res
);
  import lrp_pkg::*;

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);

  logic [CFG_W-1:0]     active_frames_r;
  logic [PAGE_BITS-1:0] req_page_r;
  logic                 req_last_r;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     n_nxt;
  logic [FRAMES-1:0]    hit_vec_r;
  logic [FRAMES-1:0]    empty_vec_r;
  logic [FRAMES-1:0]    hit_vec_nxt;
  logic [FRAMES-1:0]    empty_vec_nxt;
  logic [IDX_W-1:0]     scan_cnt_r;
  logic [IDX_W-1:0]     best_r;
  logic [IDX_W-1:0]     victim_r;
  logic [PAGE_BITS-1:0] page_r [FRAMES];
  logic [FRAMES-1:0]    valid_r;
  logic [IDX_W-1:0]     rank_r [FRAMES];
  logic [IDX_W-1:0]     rank_nxt [FRAMES];
  logic [FAULT_W-1:0]   faults_r;
  logic [FAULT_W-1:0]   faults_nxt;
  logic                 out_valid_r;
  out_t                 out_res_r;
  out_t                 out_res_nxt;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     empty_idx;
  logic [IDX_W-1:0]     tgt;
  logic [IDX_W-1:0]     old_rank;
  logic [IDX_W-1:0]     scan_rank;
  logic                 is_fill;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_frames_r <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_frames_r <= cfg_wdata;
    end
  end

  // Clamp the frame count into one to FRAMES.
  always_comb begin
    if (active_frames_r == '0) begin
      n_nxt = CNT_W'(1);
    end else if (32'(active_frames_r) > FRAMES) begin
      n_nxt = CNT_W'(FRAMES);
    end else begin
      n_nxt = CNT_W'(active_frames_r);
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_page_r <= in_req.page_number;
      req_last_r <= in_req.last_request;
      n_r        <= n_nxt;
    end
  end

  // Parallel tag compare and empty search over the active frames.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      hit_vec_nxt[i]   = (CNT_W'(i) < n_r) && valid_r[i] && (page_r[i] == req_page_r);
      empty_vec_nxt[i] = (CNT_W'(i) < n_r) && !valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit_vec_r   <= hit_vec_nxt;
      empty_vec_r <= empty_vec_nxt;
    end
  end

  // Lowest-numbered hit and lowest-numbered empty frame.
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (hit_vec_r[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (empty_vec_r[i]) begin
        empty_idx = IDX_W'(i);
      end
    end
  end

  assign status.any_hit   = |hit_vec_r;
  assign status.any_empty = |empty_vec_r;
  assign status.scan_last = (CNT_W'(scan_cnt_r) + CNT_W'(1)) == n_r;

  // Victim scan: one rank per cycle, the first frame with the highest rank wins.
  assign scan_rank = rank_r[scan_cnt_r];

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_cnt_r <= '0;
    end else if (cmd.scan_step) begin
      scan_cnt_r <= scan_cnt_r + IDX_W'(1);
      if ((scan_cnt_r == '0) || (scan_rank > best_r)) begin
        best_r   <= scan_rank;
        victim_r <= scan_cnt_r;
      end
    end
  end

  // Frame chosen for the commit and its recency update.
  always_comb begin
    unique case (cmd.kind)
      CK_HIT:   tgt = hit_idx;
      CK_FILL:  tgt = empty_idx;
      CK_EVICT: tgt = victim_r;
      default:  tgt = victim_r;
    endcase
    is_fill  = (cmd.kind == CK_FILL);
    old_rank = rank_r[tgt];
    for (int i = 0; i < FRAMES; i++) begin
      if (IDX_W'(i) == tgt) begin
        rank_nxt[i] = '0;
      end else if (valid_r[i] && (is_fill || (rank_r[i] < old_rank))) begin
        rank_nxt[i] = rank_r[i] + IDX_W'(1);
      end else begin
        rank_nxt[i] = rank_r[i];
      end
    end
  end

  // Saturating fault counter.
  always_comb begin
    if ((cmd.kind != CK_HIT) && (faults_r != '1)) begin
      faults_nxt = faults_r + FAULT_W'(1);
    end else begin
      faults_nxt = faults_r;
    end
  end

  // Result assembled from the pre-update frame contents.
  always_comb begin
    out_res_nxt.hit           = (cmd.kind == CK_HIT);
    out_res_nxt.frame_sel     = FIDX_W'(tgt);
    out_res_nxt.evicted_valid = (cmd.kind == CK_EVICT);
    out_res_nxt.evicted_page  = (cmd.kind == CK_EVICT) ? page_r[tgt] : '0;
    out_res_nxt.fault_count   = faults_nxt;
  end

  // Frame state; a final request clears it after its result is formed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      faults_r <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (req_last_r) begin
        valid_r  <= '0;
        faults_r <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          rank_r[i] <= '0;
        end
      end else begin
        valid_r[tgt] <= 1'b1;
        faults_r     <= faults_nxt;
        for (int i = 0; i < FRAMES; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
    end
  end

  // Page tags are written on a miss only.
  always_ff @(posedge clk) begin
    if (cmd.commit && (cmd.kind != CK_HIT)) begin
      page_r[tgt] <= req_page_r;
    end
  end

  // Result register, shown for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== sv/lrp_ctrl.sv =====
module lrp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lrp_pkg::status_t  status,
  output logic              busy,
  output lrp_pkg::cmd_t     cmd
);
  import lrp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH:  state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (status.any_hit || status.any_empty) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = ST_EVICT;
        end
      end
      ST_EVICT:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd  = '{load: 1'b0, match: 1'b0, scan_init: 1'b0, scan_step: 1'b0,
             commit: 1'b0, kind: CK_HIT};
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
      end
      ST_DECIDE: begin
        priority if (status.any_hit) begin
          cmd.commit = 1'b1;
          cmd.kind   = CK_HIT;
        end else if (status.any_empty) begin
          cmd.commit = 1'b1;
          cmd.kind   = CK_FILL;
        end else begin
          cmd.scan_init = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_EVICT: begin
        cmd.commit = 1'b1;
        cmd.kind   = CK_EVICT;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/lru_page_replacement.sv =====
// Fully associative LRU page replacement over up to FRAMES frames. A request item is taken
// when start is high and busy is low; its result appears on out_res for exactly one cycle
// with out_valid high and cannot be held off, so the receiver must take it in that cycle.
// A hit or a fill of an empty frame gives its result after tag compare, decision and
// commit, and the next request can be taken while that result is shown. A miss with
// every active frame full runs a victim scan over the active frames, one recency rank
// per cycle, before the eviction is committed.
// cfg_wdata written with cfg_we sets the active frame count (0 acts as 1, values above
// FRAMES act as FRAMES); write it only while busy is low and no result is pending.
// A request marked last_request clears all frames and the fault count after its result.
module lru_page_replacement #(
  parameter int FRAMES = lrp_pkg::FRAMES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  lrp_pkg::in_t              in_req,
  output logic                      out_valid,
  output lrp_pkg::out_t             out_res,
  input  logic                      cfg_we,
  input  logic [lrp_pkg::CFG_W-1:0] cfg_wdata
);
  import lrp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  lrp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Frame store, compare, victim scan and result register.
  lrp_datapath #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

`ifndef NO_ASSERTIONS
  // A result only follows a busy cycle, and the block is idle when it is shown.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result shown without a preceding busy cycle");

  // An accepted item makes the block busy.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // A fault always counts at least one fault.
  a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.hit) |-> (out_res.fault_count != '0))
    else $error("fault reported with zero fault count");

  // An eviction never comes with a hit.
  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.evicted_valid) |-> !out_res.hit)
    else $error("eviction reported on a hit");
`endif

endmodule
